// ----- rtl/core/sm4_block_cipher_core_assert.svh -----
// ----------------------------------------------------------------------------
// SM4 core assertion macros
// Clocked property checks for the SM4 block cipher core; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SM4_BLOCK_CIPHER_CORE_ASSERT_SVH
`define SM4_BLOCK_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check on every rising clk edge, off while reset is asserted
`define SM4_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check, tied to a state code of the sequencer
`define SM4_ASSERT_IN_STATE(lbl, st, prop, msg) \
	`SM4_ASSERT(lbl, (state_q == st) |-> prop, msg)

`else

`define SM4_ASSERT(lbl, prop, msg)

`define SM4_ASSERT_IN_STATE(lbl, st, prop, msg)

`endif

`endif

// ----- rtl/core/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// SM4 package
// Constants, tables and round functions shared by the SM4 core.
// ----------------------------------------------------------------------------
package sm4_pkg;

	localparam int unsigned ROUND_COUNT = 32;
	localparam int unsigned RND_W       = $clog2(ROUND_COUNT);
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned KEY_W       = 64;
	localparam int unsigned CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY,
		ST_RUN
	} sm4_state_t;

	localparam word_t FK [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam word_t CK [ROUND_COUNT] = '{
		32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
		32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
		32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
		32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
		32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
		32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
		32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
		32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// tau: S-box on each byte
	function automatic word_t sbox_word(input word_t v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	// L for data rounds: rotations by 2, 10, 18, 24
	function automatic word_t l_data(input word_t b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
		         ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	// L' for the key schedule: rotations by 13, 23
	function automatic word_t l_key(input word_t b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

endpackage

// ----- rtl/core/sm4_block_cipher_core.sv -----
// ----------------------------------------------------------------------------
// SM4 block cipher core
// 128-bit SM4 encrypt/decrypt, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                Payload
// -------   ----------------------   ------------------------------------------
// input     start & !busy            operation, in_word_a .. in_word_d
// result    done (1-cycle strobe)    out_word_a .. out_word_d
// config    cfg_valid & cfg_ready    cfg_index, cfg_data (key_upper / key_lower)
//
// After the accept edge the item runs 32 rounds on the single round unit
// (S-box word + L); the edge ending the last round loads the result register and sets
// done. The first item after reset or a key write first runs the 32-round key schedule
// on the same unit. busy drops as done rises; with start held the next item is
// taken at the edge ending the done cycle. The result cannot be stalled.
// cfg_ready is low while busy or start is high. Reset clears keys and key-ready.
//
module sm4_block_cipher_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  sm4_pkg::word_t                  in_word_a,
	input  sm4_pkg::word_t                  in_word_b,
	input  sm4_pkg::word_t                  in_word_c,
	input  sm4_pkg::word_t                  in_word_d,
	// result items
	output logic                            done,
	output sm4_pkg::word_t                  out_word_a,
	output sm4_pkg::word_t                  out_word_b,
	output sm4_pkg::word_t                  out_word_c,
	output sm4_pkg::word_t                  out_word_d,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sm4_pkg::KEY_W-1:0]       cfg_data
);
	import sm4_pkg::*;

	`include "sm4_block_cipher_core_assert.svh"

	localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

	sm4_state_t        state_q, state_d;
	logic [RND_W-1:0]  rnd_q, rnd_d;
	logic              done_q, done_d;
	logic              keys_ready_q;
	logic [KEY_W-1:0]  key_upper_q, key_lower_q;
	logic              op_q;

	word_t             x_q [4];            // data round window
	word_t             w_q [4];            // key schedule window
	word_t             rk_mem_q [ROUND_COUNT];
	word_t             out_a_q, out_b_q, out_c_q, out_d_q;

	logic              accept;
	logic              cfg_wr;
	logic              last_rnd;
	logic [RND_W-1:0]  rk_idx;
	word_t             win [4];
	word_t             rk_sel;
	word_t             t_in, t_sub, t_lin, new_word;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	// no key write at an accepting edge: the item always sees settled keys
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign last_rnd  = (rnd_q == RND_LAST);

	// ---- shared round unit -------------------------------------------------
	// Decrypt walks the round keys from the top down.
	assign rk_idx = op_q ? (RND_LAST - rnd_q) : rnd_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			win[i] = (state_q == ST_KEY) ? w_q[i] : x_q[i];
		end
	end

	assign rk_sel   = (state_q == ST_KEY) ? CK[rnd_q] : rk_mem_q[rk_idx];
	assign t_in     = win[1] ^ win[2] ^ win[3] ^ rk_sel;
	assign t_sub    = sbox_word(t_in);
	assign t_lin    = (state_q == ST_KEY) ? l_key(t_sub) : l_data(t_sub);
	assign new_word = win[0] ^ t_lin;

	// ---- sequencer -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rnd_d   = rnd_q;
		done_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					rnd_d   = '0;
					state_d = keys_ready_q ? ST_RUN : ST_KEY;
				end
			end
			ST_KEY: begin
				rnd_d = rnd_q + 1'b1;
				if (last_rnd) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				rnd_d = rnd_q + 1'b1;
				if (last_rnd) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- key registers and key-ready flag ----------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q  <= '0;
			key_lower_q  <= '0;
			keys_ready_q <= 1'b0;
		end else begin
			if (cfg_wr && (cfg_index == REG_KEY_UPPER)) begin
				key_upper_q  <= cfg_data;
				keys_ready_q <= 1'b0;
			end else if (cfg_wr && (cfg_index == REG_KEY_LOWER)) begin
				key_lower_q  <= cfg_data;
				keys_ready_q <= 1'b0;
			end else if ((state_q == ST_KEY) && last_rnd) begin
				keys_ready_q <= 1'b1;
			end
		end
	end

	// ---- datapath registers ------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			x_q[0] <= in_word_a;
			x_q[1] <= in_word_b;
			x_q[2] <= in_word_c;
			x_q[3] <= in_word_d;
		end else if (state_q == ST_RUN) begin
			x_q[0] <= x_q[1];
			x_q[1] <= x_q[2];
			x_q[2] <= x_q[3];
			x_q[3] <= new_word;
		end
	end

	// key schedule window: K = MK ^ FK, then one word per round
	always_ff @(posedge clk) begin
		if (accept && !keys_ready_q) begin
			w_q[0] <= key_upper_q[63:32] ^ FK[0];
			w_q[1] <= key_upper_q[31:0]  ^ FK[1];
			w_q[2] <= key_lower_q[63:32] ^ FK[2];
			w_q[3] <= key_lower_q[31:0]  ^ FK[3];
		end else if (state_q == ST_KEY) begin
			w_q[0] <= w_q[1];
			w_q[1] <= w_q[2];
			w_q[2] <= w_q[3];
			w_q[3] <= new_word;
		end
	end

	// round-key store, written once per key schedule round
	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) begin
			rk_mem_q[rnd_q] <= new_word;
		end
	end

	// result register: words leave reversed (X35, X34, X33, X32)
	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && last_rnd) begin
			out_a_q <= new_word;
			out_b_q <= x_q[3];
			out_c_q <= x_q[2];
			out_d_q <= x_q[1];
		end
	end

	assign done       = done_q;
	assign out_word_a = out_a_q;
	assign out_word_b = out_b_q;
	assign out_word_c = out_c_q;
	assign out_word_d = out_d_q;

	// ---- checks --------------------------------------------------------------
	`SM4_ASSERT(a_done_idle, done |-> !busy, "done strobe while busy")
	`SM4_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not go busy")
	`SM4_ASSERT(a_done_pulse, done |=> !done, "done held longer than one cycle")
	`SM4_ASSERT_IN_STATE(a_run_keys, ST_RUN, keys_ready_q, "data rounds without round keys")

endmodule

// ----- dv/sm4_cipher_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 cipher checker
// Independent SM4 predictor and result scoreboard for the cipher core bench.
// ----------------------------------------------------------------------------
package sm4_cipher_check_pkg;

	import sm4_pkg::word_t;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// register indexes with no register behind them
	localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam word_t KEY_MASK [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] SUBST_TABLE [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef struct packed {
		word_t w_a;
		word_t w_b;
		word_t w_c;
		word_t w_d;
	} cipher_block_t;

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic word_t subst(input word_t v);
		return {SUBST_TABLE[v[31:24]], SUBST_TABLE[v[23:16]],
		        SUBST_TABLE[v[15:8]], SUBST_TABLE[v[7:0]]};
	endfunction

	// CK byte j of word i is (4i + j) * 7 mod 256
	function automatic word_t ck_word(input int unsigned i);
		word_t w;
		for (int unsigned j = 0; j < 4; j++)
			w[31 - 8*j -: 8] = 8'(((4 * i) + j) * 7);
		return w;
	endfunction

	class sm4_scoreboard;
		logic [63:0]   key_upper_q;
		logic [63:0]   key_lower_q;
		word_t         round_keys [32];
		bit            keys_ready;
		cipher_block_t expected_q [$];
		int unsigned   errors;

		function new();
			key_upper_q = '0;
			key_lower_q = '0;
			keys_ready  = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(input logic [sm4_pkg::CFG_IDX_W-1:0] idx,
		                        input logic [63:0] data);
			if (idx == sm4_pkg::REG_KEY_UPPER) begin
				key_upper_q = data;
				keys_ready  = 1'b0;
			end else if (idx == sm4_pkg::REG_KEY_LOWER) begin
				key_lower_q = data;
				keys_ready  = 1'b0;
			end
		endfunction

		function void expand_keys();
			word_t w [4];
			word_t b;
			w[0] = key_upper_q[63:32] ^ KEY_MASK[0];
			w[1] = key_upper_q[31:0]  ^ KEY_MASK[1];
			w[2] = key_lower_q[63:32] ^ KEY_MASK[2];
			w[3] = key_lower_q[31:0]  ^ KEY_MASK[3];
			for (int unsigned i = 0; i < 32; i++) begin
				b = subst(w[(i+1)%4] ^ w[(i+2)%4] ^ w[(i+3)%4] ^ ck_word(i));
				w[i%4] ^= b ^ rotl(b, 13) ^ rotl(b, 23);
				round_keys[i] = w[i%4];
			end
			keys_ready = 1'b1;
		endfunction

		function void note_item(input logic op, input word_t a, input word_t b,
		                        input word_t c, input word_t d);
			word_t x [4];
			word_t rk;
			word_t s;
			if (!keys_ready)
				expand_keys();
			x = '{a, b, c, d};
			for (int unsigned i = 0; i < 32; i++) begin
				rk = (op == OP_DECRYPT) ? round_keys[31 - i] : round_keys[i];
				s  = subst(x[(i+1)%4] ^ x[(i+2)%4] ^ x[(i+3)%4] ^ rk);
				x[i%4] ^= s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
			end
			expected_q.push_back('{x[3], x[2], x[1], x[0]});
		endfunction

		function void check_result(input word_t a, input word_t b,
		                           input word_t c, input word_t d);
			cipher_block_t exp_blk;
			if (expected_q.size() == 0) begin
				$error("result with nothing outstanding: %h %h %h %h", a, b, c, d);
				errors++;
				return;
			end
			exp_blk = expected_q.pop_front();
			if (a !== exp_blk.w_a) begin
				$error("out_word_a expected %h actual %h", exp_blk.w_a, a);
				errors++;
			end
			if (b !== exp_blk.w_b) begin
				$error("out_word_b expected %h actual %h", exp_blk.w_b, b);
				errors++;
			end
			if (c !== exp_blk.w_c) begin
				$error("out_word_c expected %h actual %h", exp_blk.w_c, c);
				errors++;
			end
			if (d !== exp_blk.w_d) begin
				$error("out_word_d expected %h actual %h", exp_blk.w_d, d);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

// ----- dv/sm4_block_cipher_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 block cipher core testbench
// Drives encrypt and decrypt items under changing keys and idle patterns and
// checks every result block against an independent SM4 predictor.
// ----------------------------------------------------------------------------
module sm4_block_cipher_core_test;

	import sm4_pkg::*;
	import sm4_cipher_check_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  operation = OP_ENCRYPT;
	word_t                 in_word_a = '0;
	word_t                 in_word_b = '0;
	word_t                 in_word_c = '0;
	word_t                 in_word_d = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_UPPER;
	logic [KEY_W-1:0]      cfg_data  = '0;

	logic                  busy;
	logic                  done;
	logic                  cfg_ready;
	word_t                 out_word_a;
	word_t                 out_word_b;
	word_t                 out_word_c;
	word_t                 out_word_d;

	sm4_scoreboard         sb;

	sm4_block_cipher_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.in_word_a  (in_word_a),
		.in_word_b  (in_word_b),
		.in_word_c  (in_word_c),
		.in_word_d  (in_word_d),
		.done       (done),
		.out_word_a (out_word_a),
		.out_word_b (out_word_b),
		.out_word_c (out_word_c),
		.out_word_d (out_word_d),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Observer: key writes, accepted items and result strobes, all sampled at the
	// same edge the block sees them. Writes only happen while the core is idle,
	// so their order against items is fixed by the handshakes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (done)
				sb.check_result(out_word_a, out_word_b, out_word_c, out_word_d);
			if (start && !busy)
				sb.note_item(operation, in_word_a, in_word_b, in_word_c, in_word_d);
		end
	end

	// Hard stop; a correct run ends well short of this.
	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Present one item and hold it until the core takes it. start is left high
	// so a following item goes out back to back; callers drop it when idling.
	task automatic push_block(input logic op, input word_t a, input word_t b,
	                          input word_t c, input word_t d);
		start     <= 1'b1;
		operation <= op;
		in_word_a <= a;
		in_word_b <= b;
		in_word_c <= c;
		in_word_d <= d;
		do @(posedge clk); while (busy);
	endtask

	// Key write; cfg_valid stays high so writes can go back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait for every outstanding block. The first edge lets the
	// observer log an item taken at the edge we returned on.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic idle_gap();
		start <= 1'b0;
		repeat ($urandom_range(40, 1)) @(posedge clk);
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(6))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic rand_op();
		return $urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT;
	endfunction

	// New key material between bursts: one half, both halves, or a write to a
	// spare index that must leave the expanded keys alone.
	task automatic rekey();
		case ($urandom_range(4))
			0: write_reg(REG_KEY_UPPER, rand_key());
			1: write_reg(REG_KEY_LOWER, rand_key());
			2: write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, rand_key());
			default: begin
				write_reg(REG_KEY_UPPER, rand_key());
				write_reg(REG_KEY_LOWER, rand_key());
			end
		endcase
		end_writes();
	endtask

	// Random traffic in bursts of 20..120 items (the last may be shorter), a rekey after each burst.
	// idle_pct is the chance of a sender gap after an item.
	task automatic random_phase(input int unsigned n_items, input int unsigned idle_pct,
	                            input bit hold_once);
		int unsigned left;
		int unsigned burst;
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(120, 20);
			if (burst > left)
				burst = left;
			for (int unsigned k = 0; k < burst; k++) begin
				push_block(rand_op(), rand_word(), rand_word(), rand_word(), rand_word());
				if ($urandom_range(99) < idle_pct)
					idle_gap();
				// sender holds off mid-burst until the core has fully emptied
				if (hold_once && k == burst / 2) begin
					drain();
					hold_once = 1'b0;
				end
			end
			left -= burst;
			drain();
			rekey();
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed ---
		// no key written yet: the first item expands the reset (all-zero) key
		push_block(OP_ENCRYPT, '0, '0, '0, '0);
		idle_gap();
		push_block(OP_DECRYPT, '1, '1, '1, '1);
		drain();

		// standard key and block; decrypt of the known ciphertext
		write_reg(REG_KEY_UPPER, 64'h0123456789abcdef);
		write_reg(REG_KEY_LOWER, 64'hfedcba9876543210);
		end_writes();
		push_block(OP_ENCRYPT, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
		push_block(OP_DECRYPT, 32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246);
		// back to back, start held high
		push_block(OP_ENCRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h5a5a5a5a);
		push_block(OP_DECRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h5a5a5a5a);
		drain();

		// spare indexes are ignored and must not force a new key schedule
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '1);
		end_writes();
		push_block(OP_ENCRYPT, '0, '1, '0, '1);
		push_block(OP_DECRYPT, '1, '0, '1, '0);
		drain();

		// one half of the key changed only
		write_reg(REG_KEY_UPPER, '1);
		end_writes();
		push_block(OP_ENCRYPT, 32'h80000000, 32'h00000001, 32'h80000000, 32'h00000001);
		push_block(OP_DECRYPT, 32'h00000001, 32'h80000000, 32'h00000001, 32'h80000000);
		drain();

		// all-ones key
		write_reg(REG_KEY_LOWER, '1);
		end_writes();
		push_block(OP_ENCRYPT, '1, '1, '1, '1);
		push_block(OP_DECRYPT, '0, '0, '0, '0);
		drain();

		// all-zero key written explicitly
		write_reg(REG_KEY_UPPER, '0);
		write_reg(REG_KEY_LOWER, '0);
		end_writes();
		push_block(OP_ENCRYPT, 32'hdeadbeef, 32'h0badf00d, 32'h12345678, 32'hcafef00d);
		drain();

		// --- random ---
		rekey();
		random_phase(500, 0, 1'b0);
		random_phase(500, 63, 1'b1);
		random_phase(500, 20, 1'b0);

		// drain already waited; let any stray strobe show up before judging
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sm4_pkg.sv
rtl/core/sm4_block_cipher_core.sv
dv/sm4_cipher_check_pkg.sv
dv/sm4_block_cipher_core_test.sv
